### rtl/trf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants of the trapezoidal filter
// Register map, configuration record, field widths and tap length helper.
// ----------------------------------------------------------------------------
package trf_pkg;

    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF   = 16;

    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 10;
    localparam int SUM_W    = 24;
    localparam int VALUE_W  = 25;
    localparam int POS_W    = 16;
    localparam int DEPTH_CW = 13;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int NUM_TAPS = 3;

    typedef enum logic [1:0] {
        REG_RISE  = 2'd0,
        REG_GAP   = 2'd1,
        REG_START = 2'd2,
        REG_END   = 2'd3
    } reg_idx_t;

    localparam logic [7:0]       RISE_RST  = 8'd10;
    localparam logic [7:0]       GAP_RST   = 8'd4;
    localparam logic [POS_W-1:0] START_RST = 16'd0;
    localparam logic [POS_W-1:0] END_RST   = 16'hFFFF;

    typedef struct packed {
        logic [7:0]       rise;
        logic [7:0]       gap;
        logic [POS_W-1:0] start_index;
        logic [POS_W-1:0] end_index;
    } cfg_t;

    // Distances back from the current position of the three history taps.
    typedef struct packed {
        logic [TAP_W-1:0] near;
        logic [TAP_W-1:0] mid;
        logic [TAP_W-1:0] far;
    } tap_len_t;

    function automatic tap_len_t tap_lengths(input logic [7:0] rise, input logic [7:0] gap);
        tap_len_t t;
        t.near = TAP_W'(rise);
        t.mid  = TAP_W'(rise) + TAP_W'(gap);
        t.far  = TAP_W'(rise) + TAP_W'(rise) + TAP_W'(gap);
        return t;
    endfunction

endpackage
`default_nettype wire

### rtl/trf_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trf_regs: configuration registers
// APB-style register file holding rise, gap, start and end settings.
// ----------------------------------------------------------------------------
module trf_regs
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [trf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [trf_pkg::DATA_W-1:0]   pwdata,
    output logic      [trf_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output trf_pkg::cfg_t                     cfg,
    output logic                              tap_reload
);

    trf_pkg::cfg_t     cfg_reg;
    logic              tap_reload_reg;
    logic              wr_en;
    trf_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = trf_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise        <= trf_pkg::RISE_RST;
            cfg_reg.gap         <= trf_pkg::GAP_RST;
            cfg_reg.start_index <= trf_pkg::START_RST;
            cfg_reg.end_index   <= trf_pkg::END_RST;
            tap_reload_reg      <= 1'b0;
        end
        else
        begin
            tap_reload_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (idx)
                    trf_pkg::REG_RISE:
                    begin
                        cfg_reg.rise   <= pwdata[7:0];
                        tap_reload_reg <= 1'b1;
                    end
                    trf_pkg::REG_GAP:
                    begin
                        cfg_reg.gap    <= pwdata[7:0];
                        tap_reload_reg <= 1'b1;
                    end
                    trf_pkg::REG_START: cfg_reg.start_index <= pwdata[15:0];
                    trf_pkg::REG_END:   cfg_reg.end_index   <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (idx)
            trf_pkg::REG_RISE:  prdata = trf_pkg::DATA_W'(cfg_reg.rise);
            trf_pkg::REG_GAP:   prdata = trf_pkg::DATA_W'(cfg_reg.gap);
            trf_pkg::REG_START: prdata = trf_pkg::DATA_W'(cfg_reg.start_index);
            trf_pkg::REG_END:   prdata = trf_pkg::DATA_W'(cfg_reg.end_index);
            default:            prdata = '0;
        endcase
    end

    assign cfg        = cfg_reg;
    assign tap_reload = tap_reload_reg;

endmodule
`default_nettype wire

### rtl/trf_offset.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trf_offset: tap offset reduction
// Reduces each tap distance modulo the history depth by repeated subtraction,
// one subtraction per tap per cycle, and flags busy until all are reduced.
// ----------------------------------------------------------------------------
module trf_offset #(
    parameter int HISTORY_DEPTH = trf_pkg::HISTORY_DEPTH_DEF
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire trf_pkg::cfg_t                                cfg,
    input  wire logic                                         reload,
    output logic [trf_pkg::NUM_TAPS-1:0][$clog2(HISTORY_DEPTH)-1:0] offset,
    output logic                                              busy
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int TW = trf_pkg::TAP_W;
    localparam int CW = trf_pkg::DEPTH_CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    trf_pkg::tap_len_t rst_len;
    trf_pkg::tap_len_t new_len;
    logic [trf_pkg::NUM_TAPS-1:0][TW-1:0] rem_reg;
    logic [trf_pkg::NUM_TAPS-1:0][TW-1:0] rem_next;
    logic [trf_pkg::NUM_TAPS-1:0]         over;

    assign rst_len = trf_pkg::tap_lengths(trf_pkg::RISE_RST, trf_pkg::GAP_RST);
    assign new_len = trf_pkg::tap_lengths(cfg.rise, cfg.gap);

    always_comb
    begin
        for (int g = 0; g < trf_pkg::NUM_TAPS; g++)
        begin
            over[g]     = {{(CW-TW){1'b0}}, rem_reg[g]} >= DEPTH_C;
            rem_next[g] = over[g] ? rem_reg[g] - TW'(HISTORY_DEPTH) : rem_reg[g];
            offset[g]   = AW'(rem_reg[g]);
        end
        if (reload)
        begin
            rem_next[0] = new_len.near;
            rem_next[1] = new_len.mid;
            rem_next[2] = new_len.far;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg[0] <= rst_len.near;
            rem_reg[1] <= rst_len.mid;
            rem_reg[2] <= rst_len.far;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    // A reload in flight counts as busy so stale offsets are never used.
    assign busy = reload | (|over);

endmodule
`default_nettype wire

### rtl/trf_history.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trf_history: sample history
// Three copies of the sample history, one per tap, each written with every
// accepted sample and read at that tap's address with registered data.
// ----------------------------------------------------------------------------
module trf_history #(
    parameter int HISTORY_DEPTH = trf_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = trf_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                                                clk,
    input  wire logic                                                en,
    input  wire logic [$clog2(HISTORY_DEPTH)-1:0]                    wr_ptr,
    input  wire logic [SAMPLE_BITS-1:0]                              wr_data,
    input  wire logic [trf_pkg::NUM_TAPS-1:0][$clog2(HISTORY_DEPTH)-1:0] offset,
    output logic      [trf_pkg::NUM_TAPS-1:0][SAMPLE_BITS-1:0]       rd_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [trf_pkg::NUM_TAPS-1:0][AW:0]   diff;
    logic [trf_pkg::NUM_TAPS-1:0][AW-1:0] rd_addr;

    // Address of a tap is the write pointer minus its offset, wrapped.
    always_comb
    begin
        for (int g = 0; g < trf_pkg::NUM_TAPS; g++)
        begin
            diff[g] = {1'b0, wr_ptr} - {1'b0, offset[g]};
            if (diff[g][AW])
            begin
                rd_addr[g] = AW'(diff[g] + (AW+1)'(HISTORY_DEPTH));
            end
            else
            begin
                rd_addr[g] = diff[g][AW-1:0];
            end
        end
    end

    for (genvar g = 0; g < trf_pkg::NUM_TAPS; g++)
    begin : g_tap
        logic [SAMPLE_BITS-1:0] mem [HISTORY_DEPTH];

        // Read returns the old entry when it is the one written this cycle.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mem[wr_ptr] <= wr_data;
                rd_data[g]  <= mem[rd_addr[g]];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/trapezoidal_filter.sv
`default_nettype none
// A sample word accepted at the input passes the tap-stage registers, then the
// result register. Throughput: one word per cycle while the offsets are not busy
// and the result output is not stalled, limited by the single tap-read stage of
// the history memories. After a write of the rise or gap register, input is held
// off while the tap offsets are reloaded and reduced; after reset, only the latter.
// Reset is asynchronous, active low; it restores config, pointers, sums and valid flags.
// ----------------------------------------------------------------------------
// trapezoidal_filter: trapezoidal shaping filter
// Running right and left window sums updated from three history taps, one result
// word per sample position below end index, zero until start index and full window.
// ----------------------------------------------------------------------------
module trapezoidal_filter #(
    parameter int HISTORY_DEPTH = trf_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = trf_pkg::SAMPLE_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [trf_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [trf_pkg::DATA_W-1:0]          pwdata,
    output logic      [trf_pkg::DATA_W-1:0]          prdata,
    output logic                                     pready,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire logic [trf_pkg::SAMPLE_W-1:0]        sample,
    input  wire logic                                trace_start,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic signed [trf_pkg::VALUE_W-1:0]       filter_value,
    output logic        [trf_pkg::POS_W-1:0]         position,
    output logic                                     last
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = trf_pkg::POS_W;
    localparam int SW = trf_pkg::SUM_W;
    localparam int VW = trf_pkg::VALUE_W;
    localparam int NT = trf_pkg::NUM_TAPS;

    trf_pkg::cfg_t     cfg;
    trf_pkg::tap_len_t len;
    logic              tap_reload;
    logic              busy;
    logic [NT-1:0][AW-1:0] offset;
    logic [NT-1:0][SB-1:0] rd_data;
    logic [NT-1:0][trf_pkg::TAP_W-1:0] tap_dist;

    // Input side.
    logic          accept;
    logic [PW-1:0] pos_eff;
    logic [AW-1:0] wp_eff;
    logic [SB-1:0] samp;
    logic [PW-1:0] window;
    logic [PW-1:0] first;
    logic [PW:0]   pos_plus;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;

    // Tap stage.
    logic          s1_valid_reg;
    logic          s1_start_reg;
    logic [SB-1:0] s1_sample_reg;
    logic [NT-1:0] s1_self_reg;
    logic [NT-1:0] s1_zero_reg;
    logic          s1_below_reg;
    logic          s1_result_reg;
    logic          s1_last_reg;
    logic [PW-1:0] s1_pos_reg;
    logic          s1_move;
    logic          out_free;

    logic [NT-1:0][SB-1:0] tap_val;
    logic [SW-1:0] right_base;
    logic [SW-1:0] left_base;
    logic [SW-1:0] right_sum_reg;
    logic [SW-1:0] right_sum_next;
    logic [SW-1:0] left_sum_reg;
    logic [SW-1:0] left_sum_next;
    logic [VW-1:0] diff;

    // Result register.
    logic          out_valid_reg;
    logic [VW-1:0] value_reg;
    logic [PW-1:0] position_reg;
    logic          last_reg;

    trf_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .tap_reload (tap_reload)
    );

    trf_offset #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_offset (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .reload (tap_reload),
        .offset (offset),
        .busy   (busy)
    );

    trf_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_history (
        .clk     (clk),
        .en      (accept),
        .wr_ptr  (wp_eff),
        .wr_data (samp),
        .offset  (offset),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free     = !out_valid_reg || result_ready;
    assign s1_move      = s1_valid_reg && (out_free || !s1_result_reg);
    assign sample_ready = !busy && (!s1_valid_reg || s1_move);
    assign accept       = sample_valid && sample_ready;

    // ------------------------------------------------------------------
    // Input decode: position, pointer and tap selection
    // ------------------------------------------------------------------
    assign len         = trf_pkg::tap_lengths(cfg.rise, cfg.gap);
    assign tap_dist[0] = len.near;
    assign tap_dist[1] = len.mid;
    assign tap_dist[2] = len.far;

    assign samp     = sample[SB-1:0];
    assign pos_eff  = trace_start ? '0 : pos_reg;
    assign wp_eff   = trace_start ? '0 : wp_reg;
    assign window   = PW'(len.far);
    assign first    = (cfg.start_index > window) ? cfg.start_index : window;
    assign pos_plus = {1'b0, pos_eff} + (PW+1)'(1);

    always_comb
    begin
        pos_next = pos_reg;
        wp_next  = wp_reg;
        if (accept)
        begin
            // Position saturates; the saturated position never yields output.
            pos_next = pos_plus[PW] ? pos_eff : pos_plus[PW-1:0];
            wp_next  = (wp_eff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_eff + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            wp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            wp_reg  <= wp_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg  <= trace_start;
            s1_sample_reg <= samp;
            s1_below_reg  <= pos_eff < first;
            s1_result_reg <= pos_eff < cfg.end_index;
            s1_last_reg   <= pos_plus == {1'b0, cfg.end_index};
            s1_pos_reg    <= pos_eff;
            for (int g = 0; g < NT; g++)
            begin
                s1_self_reg[g] <= tap_dist[g] == '0;
                s1_zero_reg[g] <= pos_eff < PW'(tap_dist[g]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tap stage: running sums and filter value
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int g = 0; g < NT; g++)
        begin
            if (s1_self_reg[g])
            begin
                tap_val[g] = s1_sample_reg;
            end
            else if (s1_zero_reg[g])
            begin
                tap_val[g] = '0;
            end
            else
            begin
                tap_val[g] = rd_data[g];
            end
        end
        right_base     = s1_start_reg ? '0 : right_sum_reg;
        left_base      = s1_start_reg ? '0 : left_sum_reg;
        right_sum_next = right_base + SW'(s1_sample_reg) - SW'(tap_val[0]);
        left_sum_next  = left_base + SW'(tap_val[1]) - SW'(tap_val[2]);
        diff           = {1'b0, right_base} - {1'b0, left_base};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_sum_reg <= '0;
            left_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                right_sum_reg <= right_sum_next;
                left_sum_reg  <= left_sum_next;
            end
            if (s1_move && s1_result_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_result_reg)
        begin
            value_reg    <= s1_below_reg ? '0 : diff;
            position_reg <= s1_pos_reg;
            last_reg     <= s1_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign filter_value = $signed(value_reg);
    assign position     = position_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire
